// File: sv/svm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svm_pkg;

    localparam int SMP_W  = 8;
    localparam int VOL_W  = 18;
    localparam int PAN_W  = 16;
    localparam int GAIN_W = 18;
    localparam int OPR_W  = 19;
    localparam int PROD_W = 2 * OPR_W;
    localparam int ADD_W  = 11;
    localparam int SUM_W  = 12;

    localparam logic [GAIN_W-1:0] UNITY   = 18'h10000;
    localparam logic [GAIN_W-1:0] TWICE   = 18'h20000;
    localparam logic [SMP_W-1:0]  SILENCE = 8'h80;
    localparam logic [SMP_W-1:0]  LEVEL_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_MIX_L,
        ST_MIX_R,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_GAIN_L,
        MUL_GAIN_R,
        MUL_MIX_L,
        MUL_MIX_R
    } t_mul_sel;

    typedef struct packed {
        logic     capture;
        t_mul_sel mul_sel;
        logic     load_gain_l;
        logic     load_gain_r;
        logic     upd_l;
        logic     upd_r;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_status;

    // Adds a signed increment to an unsigned level and clamps to 0..255.
    function automatic logic [SMP_W-1:0] mix_clamp(input logic [SMP_W-1:0] acc,
                                                   input logic signed [ADD_W-1:0] add);
        logic signed [SUM_W-1:0] s;
        s = $signed({{(SUM_W-SMP_W){1'b0}}, acc}) + SUM_W'(add);
        if (s < 0) begin
            return '0;
        end else if (s > $signed({{(SUM_W-SMP_W){1'b0}}, LEVEL_MAX})) begin
            return LEVEL_MAX;
        end
        return s[SMP_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/svm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface svm_in_if;
    logic                      valid;
    logic                      ready;
    logic [svm_pkg::SMP_W-1:0] sample_byte;
    logic [svm_pkg::VOL_W-1:0] voice_gain;
    logic [svm_pkg::PAN_W-1:0] pan_pos;
    logic                      voice_active;
    logic                      last_voice;

    modport source (output valid, sample_byte, voice_gain, pan_pos, voice_active,
                    last_voice, input ready);
    modport sink (input valid, sample_byte, voice_gain, pan_pos, voice_active,
                  last_voice, output ready);
endinterface

interface svm_out_if;
    logic                      valid;
    logic                      ready;
    logic [svm_pkg::SMP_W-1:0] left_level;
    logic [svm_pkg::SMP_W-1:0] right_level;

    modport source (output valid, left_level, right_level, input ready);
    modport sink (input valid, left_level, right_level, output ready);
endinterface

`default_nettype wire

// File: sv/stereo_voice_mixer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Stereo voice mixer: one voice word per input handshake, carrying an 8-bit
// sample, a 2.16 volume and a pan position; a word with last_voice set closes
// the frame and produces one output word with the clamped left and right
// levels, after which both channels return to silence (128). For each voice,
// a single 19x19 multiplier is used four times in turn (left gain, right
// gain, left and right sample scaling) and a final state finishes the right
// channel, in which the next voice word can already be taken. A frame-closing
// voice holds in that final state while a previous frame word is still
// waiting at the output.
module stereo_voice_mixer_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    svm_in_if.sink     i_voice,
    svm_out_if.source  o_frame
);

    svm_pkg::t_cmd    w_cmd;
    svm_pkg::t_status w_status;
    logic             w_in_ready;

    assign i_voice.ready = w_in_ready;

    svm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_voice.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    svm_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_voice  (i_voice),
        .o_frame  (o_frame)
    );

endmodule

`default_nettype wire

// File: sv/svm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module svm_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  svm_pkg::t_status  i_status,
    output logic              o_in_ready,
    output svm_pkg::t_cmd     o_cmd
);

    svm_pkg::t_state r_state;
    svm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = svm_pkg::MUL_NONE;
        case (r_state)
            svm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = svm_pkg::ST_GAIN_L;
                end
            end
            svm_pkg::ST_GAIN_L: begin
                o_cmd.mul_sel = svm_pkg::MUL_GAIN_L;
                n_state       = svm_pkg::ST_GAIN_R;
            end
            svm_pkg::ST_GAIN_R: begin
                o_cmd.mul_sel     = svm_pkg::MUL_GAIN_R;
                o_cmd.load_gain_l = 1'b1;
                n_state           = svm_pkg::ST_MIX_L;
            end
            svm_pkg::ST_MIX_L: begin
                o_cmd.mul_sel     = svm_pkg::MUL_MIX_L;
                o_cmd.load_gain_r = 1'b1;
                n_state           = svm_pkg::ST_MIX_R;
            end
            svm_pkg::ST_MIX_R: begin
                o_cmd.mul_sel = svm_pkg::MUL_MIX_R;
                o_cmd.upd_l   = 1'b1;
                n_state       = svm_pkg::ST_FIN;
            end
            svm_pkg::ST_FIN: begin
                // A frame-closing voice waits here until the output word is free.
                if (!i_status.last || i_status.out_free) begin
                    o_cmd.upd_r = 1'b1;
                    o_cmd.emit  = i_status.last;
                    o_in_ready  = 1'b1;
                    n_state     = i_in_valid ? svm_pkg::ST_GAIN_L : svm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = svm_pkg::ST_IDLE;
            end
        endcase
        o_cmd.capture = i_in_valid && o_in_ready;
    end

endmodule

`default_nettype wire

// File: sv/svm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module svm_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  svm_pkg::t_cmd     i_cmd,
    output svm_pkg::t_status  o_status,
    svm_in_if.sink            i_voice,
    svm_out_if.source         o_frame
);

    logic [svm_pkg::SMP_W-1:0]  r_smp;
    logic [svm_pkg::VOL_W-1:0]  r_vol;
    logic [svm_pkg::PAN_W-1:0]  r_pan;
    logic                       r_active;
    logic                       r_last;
    logic signed [svm_pkg::PROD_W-1:0] r_prod;
    logic [svm_pkg::GAIN_W-1:0] r_gain_l;
    logic [svm_pkg::GAIN_W-1:0] r_gain_r;
    logic [svm_pkg::SMP_W-1:0]  r_left;
    logic [svm_pkg::SMP_W-1:0]  r_right;
    logic                       r_out_valid;
    logic [svm_pkg::SMP_W-1:0]  r_out_l;
    logic [svm_pkg::SMP_W-1:0]  r_out_r;

    logic [svm_pkg::GAIN_W-1:0] w_pan2;
    logic [svm_pkg::GAIN_W-1:0] w_pan_l;
    logic [svm_pkg::GAIN_W-1:0] w_pan_r;
    logic signed [svm_pkg::OPR_W-1:0] w_smp_s;
    logic signed [svm_pkg::OPR_W-1:0] w_opa;
    logic signed [svm_pkg::OPR_W-1:0] w_opb;
    logic signed [svm_pkg::PROD_W-1:0] w_prod;
    logic signed [svm_pkg::ADD_W-1:0]  w_add;
    logic [svm_pkg::SMP_W-1:0]  w_left_next;
    logic [svm_pkg::SMP_W-1:0]  w_right_next;

    // Pan law: the far side of center is attenuated, the near side stays at unity.
    assign w_pan2  = {1'b0, r_pan, 1'b0};
    assign w_pan_l = r_pan[svm_pkg::PAN_W-1] ? (svm_pkg::TWICE - w_pan2) : svm_pkg::UNITY;
    assign w_pan_r = r_pan[svm_pkg::PAN_W-1] ? svm_pkg::UNITY : w_pan2;

    // Sample minus the silence level, as a sign-extended operand.
    assign w_smp_s = $signed({{(svm_pkg::OPR_W-svm_pkg::SMP_W){~r_smp[svm_pkg::SMP_W-1]}},
                              ~r_smp[svm_pkg::SMP_W-1], r_smp[svm_pkg::SMP_W-2:0]});

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (i_cmd.mul_sel)
            svm_pkg::MUL_GAIN_L: begin
                w_opa = $signed({1'b0, w_pan_l});
                w_opb = $signed({1'b0, r_vol});
            end
            svm_pkg::MUL_GAIN_R: begin
                w_opa = $signed({1'b0, w_pan_r});
                w_opb = $signed({1'b0, r_vol});
            end
            svm_pkg::MUL_MIX_L: begin
                w_opa = w_smp_s;
                w_opb = $signed({1'b0, r_gain_l});
            end
            svm_pkg::MUL_MIX_R: begin
                w_opa = w_smp_s;
                w_opb = $signed({1'b0, r_gain_r});
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_prod = w_opa * w_opb;

    // Dropping the low 16 bits of a two's complement product floors it.
    assign w_add        = $signed(r_prod[16 +: svm_pkg::ADD_W]);
    assign w_left_next  = r_active ? svm_pkg::mix_clamp(r_left, w_add) : r_left;
    assign w_right_next = r_active ? svm_pkg::mix_clamp(r_right, w_add) : r_right;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_smp    <= i_voice.sample_byte;
            r_vol    <= i_voice.voice_gain;
            r_pan    <= i_voice.pan_pos;
            r_active <= i_voice.voice_active;
            r_last   <= i_voice.last_voice;
        end
        // The right product is held while a frame-closing voice waits to finish.
        if (i_cmd.mul_sel != svm_pkg::MUL_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.load_gain_l) begin
            r_gain_l <= r_prod[16 +: svm_pkg::GAIN_W];
        end
        if (i_cmd.load_gain_r) begin
            r_gain_r <= r_prod[16 +: svm_pkg::GAIN_W];
        end
        if (i_cmd.emit) begin
            r_out_l <= r_left;
            r_out_r <= w_right_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= svm_pkg::SILENCE;
            r_right     <= svm_pkg::SILENCE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_left  <= svm_pkg::SILENCE;
                r_right <= svm_pkg::SILENCE;
            end else begin
                if (i_cmd.upd_l) begin
                    r_left <= w_left_next;
                end
                if (i_cmd.upd_r) begin
                    r_right <= w_right_next;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_free = !r_out_valid || o_frame.ready;

    assign o_frame.valid       = r_out_valid;
    assign o_frame.left_level  = r_out_l;
    assign o_frame.right_level = r_out_r;

endmodule

`default_nettype wire

// File: sv/svm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module svm_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      i_in_ready,
    input wire                      i_in_last,
    input wire                      i_out_valid,
    input wire                      i_out_ready,
    input wire [svm_pkg::SMP_W-1:0] i_out_left,
    input wire [svm_pkg::SMP_W-1:0] i_out_right
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    // A waiting frame word holds its levels until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_left)
            && $stable(i_out_right))
        else $error("frame word changed while stalled");

    // Voices are worked one at a time, so two accepts are never adjacent.
    a_no_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !w_in_acc)
        else $error("voice words accepted on adjacent cycles");

    // A new frame word must come from an accepted closing voice.
    a_frame_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc && i_in_last, 6))
        else $error("frame word without a closing voice");

    // A voice that does not close the frame never raises the output.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_in_last |=> ##5 !$rose(i_out_valid))
        else $error("frame word from a voice that is not last");

endmodule

bind stereo_voice_mixer_top svm_checker u_svm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_voice.valid),
    .i_in_ready  (i_voice.ready),
    .i_in_last   (i_voice.last_voice),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_out_left  (o_frame.left_level),
    .i_out_right (o_frame.right_level)
);

`default_nettype wire
